>>> rtl/core/sesl_pkg.sv
// sesl_pkg: shared types and constants of the styled edge scanline block
// item, result and queued command structs, register indexes
// no dependencies
package sesl_pkg;

	localparam int WordBits       = 32;
	localparam int RowBits        = 16;
	localparam int ValidBitsW     = 6;
	localparam int LenBits        = 3;
	localparam int NumPatternRegs = 4;
	localparam int PosBits        = 2;
	localparam int AddrBits       = 5;
	localparam int QueueDepth     = 4;
	localparam int QueuePtrBits   = 2;
	localparam int QueueCntBits   = 3;

	typedef logic [NumPatternRegs-1:0][WordBits-1:0] pattern_t;

	typedef enum logic [2:0] {
		REG_PATTERN_0      = 3'd0,
		REG_PATTERN_1      = 3'd1,
		REG_PATTERN_2      = 3'd2,
		REG_PATTERN_3      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [WordBits-1:0]   current_word;
		logic [WordBits-1:0]   above_word;
		logic [WordBits-1:0]   below_word;
		logic [RowBits-1:0]    row_number;
		logic                  first_in_row;
		logic                  last_in_row;
		logic [ValidBitsW-1:0] valid_bits;
	} item_t;

	typedef struct packed {
		logic [WordBits-1:0] styled_word;
		logic                row_end;
	} result_t;

	// one word to style, with the row context it needs
	typedef struct packed {
		logic [WordBits-1:0] pixels;
		logic [WordBits-1:0] above;
		logic [WordBits-1:0] below;
		logic                next_bit;
		logic                row_end;
		logic                restart;
		logic                vert;
	} cmd_t;

	// front to queue push request
	typedef struct packed {
		logic [1:0] count;
		cmd_t       cmd0;
		cmd_t       cmd1;
	} push_t;

endpackage

>>> rtl/core/sesl_front.sv
// sesl_front: accepts scanline items, holds the word waiting for its right neighbor
// and turns each transfer into zero, one or two style commands
// depends on sesl_pkg
module sesl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  sesl_pkg::item_t    item,
	input  sesl_pkg::pattern_t pattern,
	input  logic [2:0]         eff_len,
	input  logic               room,
	output sesl_pkg::push_t    push
);
	import sesl_pkg::*;

	logic                held_q;
	logic                held_restart_q;
	logic                held_vert_q;
	logic [WordBits-1:0] held_cur_q;
	logic [WordBits-1:0] held_above_q;
	logic [WordBits-1:0] held_below_q;

	logic                accept;
	logic [1:0]          word_sel;
	logic                new_vert;
	logic                restart_new;
	logic [WordBits-1:0] mask;
	cmd_t                cmd_held;
	cmd_t                cmd_last;

	// base-4 digit sum, 4 mod 3 is 1
	function automatic logic [1:0] mod3(input logic [10:0] q);
		logic [11:0] x;
		logic [4:0]  s;
		x = {1'b0, q};
		s = '0;
		for (int i = 0; i < 6; i++) begin
			s = s + 5'(x[2*i +: 2]);
		end
		if (s >= 5'd12) begin
			s = s - 5'd12;
		end
		if (s >= 5'd6) begin
			s = s - 5'd6;
		end
		if (s >= 5'd3) begin
			s = s - 5'd3;
		end
		return s[1:0];
	endfunction

	assign item_stall  = !room;
	assign accept      = item_valid && room;
	assign restart_new = item.first_in_row || !held_q;

	// pattern word index is (row / 32) mod length, bit index is row mod 32
	always_comb begin
		case (eff_len)
			3'd1:    word_sel = 2'd0;
			3'd2:    word_sel = {1'b0, item.row_number[5]};
			3'd3:    word_sel = mod3(item.row_number[15:5]);
			default: word_sel = item.row_number[6:5];
		endcase
		new_vert = pattern[word_sel][item.row_number[4:0]];
	end

	always_comb begin
		if (item.valid_bits >= 6'd32) begin
			mask = '1;
		end else begin
			mask = (32'h1 << item.valid_bits[4:0]) - 32'h1;
		end
	end

	always_comb begin
		cmd_held.pixels   = held_cur_q;
		cmd_held.above    = held_above_q;
		cmd_held.below    = held_below_q;
		cmd_held.next_bit = item.first_in_row ? 1'b0 : item.current_word[0];
		cmd_held.row_end  = item.first_in_row;
		cmd_held.restart  = held_restart_q;
		cmd_held.vert     = held_vert_q;

		cmd_last.pixels   = item.current_word & mask;
		cmd_last.above    = item.above_word;
		cmd_last.below    = item.below_word;
		cmd_last.next_bit = 1'b0;
		cmd_last.row_end  = 1'b1;
		cmd_last.restart  = restart_new;
		cmd_last.vert     = new_vert;

		push.cmd0  = held_q ? cmd_held : cmd_last;
		push.cmd1  = cmd_last;
		push.count = accept ? (2'(held_q) + 2'(item.last_in_row)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= 1'b0;
			held_restart_q <= 1'b0;
			held_vert_q    <= 1'b0;
		end else if (accept) begin
			held_q <= !item.last_in_row;
			if (!item.last_in_row) begin
				held_restart_q <= restart_new;
				held_vert_q    <= new_vert;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !item.last_in_row) begin
			held_cur_q   <= item.current_word;
			held_above_q <= item.above_word;
			held_below_q <= item.below_word;
		end
	end

endmodule

>>> rtl/core/sesl_queue.sv
// sesl_queue: short command queue between front and back, up to two pushes a cycle
// depends on sesl_pkg
module sesl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  sesl_pkg::push_t push,
	input  logic            pop,
	output sesl_pkg::cmd_t  head,
	output logic            head_valid,
	output logic            room
);
	import sesl_pkg::*;

	cmd_t                    mem_q [QueueDepth];
	logic [QueuePtrBits-1:0] wr_ptr_q;
	logic [QueuePtrBits-1:0] rd_ptr_q;
	logic [QueueCntBits-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	// room for a transfer that brings two commands
	assign room       = count_q <= QueueCntBits'(QueueDepth - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.cmd0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + QueuePtrBits'(1)] <= push.cmd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QueuePtrBits'(push.count);
			rd_ptr_q <= rd_ptr_q + QueuePtrBits'(pop);
			count_q  <= count_q + QueueCntBits'(push.count) - QueueCntBits'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QueueCntBits'(QueueDepth))
		else $error("queue count above depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push without room");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

>>> rtl/core/sesl_back.sv
// sesl_back: classifies pixels of one queued word and applies the line style
// keeps the row context and the output register
// depends on sesl_pkg
module sesl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sesl_pkg::cmd_t     head,
	input  logic               head_valid,
	output logic               pop,
	input  sesl_pkg::pattern_t pattern,
	input  logic [2:0]         eff_len,
	output logic               result_valid,
	input  logic               result_stall,
	output sesl_pkg::result_t  result
);
	import sesl_pkg::*;

	logic [WordBits-1:0] left_q;
	logic [PosBits-1:0]  pos_q;
	logic                vert_q;
	logic                result_valid_q;
	result_t             result_q;

	logic [WordBits-1:0] left_eff;
	logic [PosBits-1:0]  pos_eff;
	logic                vert_eff;
	logic [PosBits-1:0]  pos_next;
	logic [LenBits-1:0]  pos_inc;
	logic [WordBits-1:0] d, hm, right_n, left_n;
	logic [WordBits-1:0] h1, h2, hi, hn, v1, v2, vi, vn;
	logic [WordBits-1:0] sol, with_h, with_v, with_hv, styled;

	assign pop          = head_valid && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		left_eff = head.restart ? '0 : left_q;
		pos_eff  = head.restart ? '0 : pos_q;
		vert_eff = head.restart ? head.vert : vert_q;

		// position wraps modulo the pattern length
		pos_inc = {1'b0, pos_eff} + 3'd1;
		case (eff_len)
			3'd1:    pos_next = 2'd0;
			3'd2:    pos_next = {1'b0, pos_inc[0]};
			3'd3:    pos_next = (pos_inc >= 3'd3) ? PosBits'(pos_inc - 3'd3) : pos_inc[1:0];
			default: pos_next = pos_inc[1:0];
		endcase

		d       = head.pixels;
		hm      = pattern[pos_eff];
		right_n = {head.next_bit, d[WordBits-1:1]};
		left_n  = {d[WordBits-2:0], left_eff[WordBits-1]};
		h1      = d & right_n;
		h2      = d & left_n;
		hi      = h1 & h2;
		hn      = h1 | h2;
		v1      = head.below & d;
		v2      = head.above & d;
		vi      = v1 & v2;
		vn      = v1 | v2;
		sol     = d & ~(hi | vi | hn | vn);
		with_h  = d & ~vi & hn;
		with_v  = d & ~hi & vn;
		with_hv = d & hi & vi & hn & vn;
		styled  = (sol | with_h) & hm;
		if (vert_eff) begin
			styled = styled | with_v | (with_hv & hm);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q         <= '0;
			pos_q          <= '0;
			vert_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (pop) begin
			left_q         <= d;
			pos_q          <= pos_next;
			vert_q         <= vert_eff;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.styled_word <= styled;
			result_q.row_end     <= head.row_end;
		end
	end

endmodule

>>> rtl/core/styled_edge_scanline.sv
// styled_edge_scanline: top level of the edge-styled scanline block
// holds the pattern registers and joins front, command queue and back
// depends on sesl_pkg, sesl_front, sesl_queue, sesl_back
//
//  channel   signals                               direction  payload
//  item      item_valid, item_stall, item          in         sesl_pkg::item_t
//  result    result_valid, result_stall, result    out        sesl_pkg::result_t
//  config    psel, penable, pwrite, paddr, pwdata,  in/out     32-bit registers at 4*i
//            prdata, pready
//
// an item's commands enter the four-entry queue at its transfer edge and pass from the
// queue head into the result register when the back pops them
// the back styles one word per cycle while the result side does not stall, so a sustained
// rate is one item per cycle except where a row-ending item also releases the held word
// and brings two results; the front stalls while the queue holds more than two commands
// reset clears control state and sets the pattern words to all ones, length one
module styled_edge_scanline #(
	parameter int MAX_PATTERN_WORDS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  sesl_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output sesl_pkg::result_t                 result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sesl_pkg::AddrBits-1:0]     paddr,
	input  logic [sesl_pkg::WordBits-1:0]     pwdata,
	output logic [sesl_pkg::WordBits-1:0]     prdata,
	output logic                              pready
);
	import sesl_pkg::*;

	// usable pattern length never exceeds the four pattern registers
	localparam int LenCap = (MAX_PATTERN_WORDS < NumPatternRegs) ?
		((MAX_PATTERN_WORDS < 1) ? 1 : MAX_PATTERN_WORDS) : NumPatternRegs;

	pattern_t           pattern_q;
	logic [LenBits-1:0] length_q;
	logic [LenBits-1:0] eff_len;
	logic               cfg_write;
	reg_index_t         reg_index;

	push_t              push;
	logic               room;
	cmd_t               head;
	logic               head_valid;
	logic               pop;

	// register file, written on the access phase of a transfer
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_index = reg_index_t'(paddr[AddrBits-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '1;
			length_q  <= LenBits'(1);
		end else if (cfg_write) begin
			case (reg_index)
				REG_PATTERN_0:      pattern_q[0] <= pwdata;
				REG_PATTERN_1:      pattern_q[1] <= pwdata;
				REG_PATTERN_2:      pattern_q[2] <= pwdata;
				REG_PATTERN_3:      pattern_q[3] <= pwdata;
				REG_PATTERN_LENGTH: length_q     <= pwdata[LenBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_PATTERN_0:      prdata = pattern_q[0];
			REG_PATTERN_1:      prdata = pattern_q[1];
			REG_PATTERN_2:      prdata = pattern_q[2];
			REG_PATTERN_3:      prdata = pattern_q[3];
			REG_PATTERN_LENGTH: prdata = WordBits'(length_q);
			default:            prdata = '0;
		endcase
	end

	// zero acts as one, anything above the cap saturates
	always_comb begin
		if (length_q == '0) begin
			eff_len = LenBits'(1);
		end else if (length_q > LenBits'(LenCap)) begin
			eff_len = LenBits'(LenCap);
		end else begin
			eff_len = length_q;
		end
	end

	// front: holds one word until its right neighbor arrives
	sesl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pattern    (pattern_q),
		.eff_len    (eff_len),
		.room       (room),
		.push       (push)
	);

	// queue decouples a stalled result from the input side
	sesl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.room       (room)
	);

	// back: edge classification, line style, output register
	sesl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.pattern      (pattern_q),
		.eff_len      (eff_len),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench: directed and random raster words through styled_edge_scanline, checked against
// a scanline predictor kept in step with each accepted item; depends on sesl_pkg and the rtl
module testbench;
	import sesl_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int IdlePercent  = 11;
	localparam int HoldAtItem   = 700;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 12;
	localparam int PhaseItems   = 385;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	item_t               item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [AddrBits-1:0] paddr        = '0;
	logic [WordBits-1:0] pwdata       = '0;
	logic [WordBits-1:0] prdata;
	logic                pready;

	styled_edge_scanline #(
		.MAX_PATTERN_WORDS(4)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// words waiting to be offered, and styled words still owed by the block
	item_t   items_to_send[$];
	result_t styled_due[$];

	int                 errors      = 0;
	int                 items_taken = 0;
	int                 cycles      = 0;
	int                 hold_left   = 0;
	bit                 hold_used   = 1'b0;
	bit                 quiet       = 1'b0;
	logic [RowBits-1:0] row_cursor  = '0;
	result_t            due;

	// shadow of the pattern registers
	logic [WordBits-1:0] pat_word [NumPatternRegs];
	logic [LenBits-1:0]  pat_len;

	// shadow of the scanline context
	logic [WordBits-1:0] held_pixels;
	logic [WordBits-1:0] held_above;
	logic [WordBits-1:0] held_below;
	logic                held_valid;
	logic [WordBits-1:0] prev_pixels;
	logic [PosBits-1:0]  pat_pos;
	logic                vert_on;

	// length in use: zero acts as one, anything past four saturates
	function automatic int unsigned live_length();
		int unsigned len;
		len = pat_len;
		if (len < 1)
			len = 1;
		if (len > NumPatternRegs)
			len = NumPatternRegs;
		return len;
	endfunction

	// new row: clear the left context and pick the vertical bit for this row
	task automatic open_row(input logic [RowBits-1:0] row);
		int unsigned b;
		b = row % (WordBits * live_length());
		prev_pixels = '0;
		pat_pos = '0;
		vert_on = pat_word[PosBits'(b / WordBits)][5'(b % WordBits)];
	endtask

	// classify each pixel by its cross neighbors and queue the styled word
	task automatic style_word(input logic [WordBits-1:0] d, input logic [WordBits-1:0] above,
			input logic [WordBits-1:0] below, input logic next_bit, input logic row_end);
		logic [WordBits-1:0] hmask, right, left, h1, h2, hi, hn, v1, v2, vi, vn;
		logic [WordBits-1:0] sol, with_h, with_v, with_hv, styled;
		hmask = pat_word[pat_pos];
		right = {next_bit, d[WordBits-1:1]};
		left = {d[WordBits-2:0], prev_pixels[WordBits-1]};
		h1 = d & right;
		h2 = d & left;
		hi = h1 & h2;
		hn = h1 | h2;
		v1 = below & d;
		v2 = above & d;
		vi = v1 & v2;
		vn = v1 | v2;
		sol = d & ~(hi | vi | hn | vn);
		with_h = d & ~vi & hn;
		with_v = d & ~hi & vn;
		with_hv = d & hi & vi & hn & vn;
		styled = (sol | with_h) & hmask;
		if (vert_on)
			styled = styled | with_v | (with_hv & hmask);
		styled_due.insert(styled_due.size(), result_t'{styled, row_end});
		prev_pixels = d;
		pat_pos = PosBits'((pat_pos + 1) % live_length());
	endtask

	// advance the shadow context by one accepted word
	task automatic advance_scanline(input item_t it);
		logic [WordBits-1:0] mask;
		// a row start while a word is held closes the old row first
		if (held_valid && it.first_in_row) begin
			style_word(held_pixels, held_above, held_below, 1'b0, 1'b1);
			held_valid = 1'b0;
		end
		// a word with nothing held opens a row even without its start flag
		if (it.first_in_row || !held_valid) begin
			open_row(it.row_number);
		end else begin
			style_word(held_pixels, held_above, held_below, it.current_word[0], 1'b0);
			held_valid = 1'b0;
		end
		if (it.last_in_row) begin
			mask = (it.valid_bits >= WordBits) ? '1 : ((32'd1 << it.valid_bits) - 1);
			style_word(it.current_word & mask, it.above_word, it.below_word, 1'b0, 1'b1);
			held_valid = 1'b0;
		end else begin
			held_pixels = it.current_word;
			held_above = it.above_word;
			held_below = it.below_word;
			held_valid = 1'b1;
		end
	endtask

	// input side: new word only when the slot is free, random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				advance_scanline(item);
				items_taken <= items_taken + 1;
			end
			if (!item_valid || !item_stall) begin
				if (items_to_send.size() != 0 && (quiet || $urandom_range(99) >= IdlePercent)) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off on the result side once traffic is under way
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (!hold_used && items_taken == HoldAtItem) begin
			hold_left <= HoldCycles;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result side: check each transfer against the oldest owed word
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (styled_due.size() == 0) begin
					$error("unexpected transfer: styled_word %h row_end %b",
						result.styled_word, result.row_end);
					errors++;
				end else begin
					due = styled_due.pop_front();
					if (result.styled_word !== due.styled_word) begin
						$error("styled_word expected %h actual %h", due.styled_word,
							result.styled_word);
						errors++;
					end
					if (result.row_end !== due.row_end) begin
						$error("row_end expected %b actual %b", due.row_end, result.row_end);
						errors++;
					end
				end
			end
			result_stall <= hold_left != 0 || (!quiet && $urandom_range(99) < IdlePercent);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// register write: setup cycle, then access cycle; psel is released by the caller
	task automatic write_reg(input reg_index_t idx, input logic [WordBits-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_PATTERN_LENGTH)
			pat_len = val[LenBits-1:0];
		else
			pat_word[PosBits'(idx)] = val;
	endtask

	task automatic configure(input logic [WordBits-1:0] w0, input logic [WordBits-1:0] w1,
			input logic [WordBits-1:0] w2, input logic [WordBits-1:0] w3,
			input logic [WordBits-1:0] len);
		write_reg(REG_PATTERN_0, w0);
		write_reg(REG_PATTERN_1, w1);
		write_reg(REG_PATTERN_2, w2);
		write_reg(REG_PATTERN_3, w3);
		write_reg(REG_PATTERN_LENGTH, len);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		// address still points at the length register
		if (prdata !== WordBits'(pat_len)) begin
			$error("pattern_length expected %h actual %h", WordBits'(pat_len), prdata);
			errors++;
		end
	endtask

	// wait for all words sent and all styled words back, then let the block settle
	task automatic drain();
		while (items_to_send.size() != 0 || item_valid || styled_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic push_item(input logic [WordBits-1:0] cur, input logic [WordBits-1:0] abv,
			input logic [WordBits-1:0] blw, input logic [RowBits-1:0] row, input logic first,
			input logic last, input logic [ValidBitsW-1:0] vbits);
		items_to_send.insert(items_to_send.size(),
			item_t'{cur, abv, blw, row, first, last, vbits});
	endtask

	function automatic logic [WordBits-1:0] pixel_word();
		case ($urandom_range(5))
			0: return $urandom & $urandom;
			1: return $urandom | $urandom;
			2: return ~(32'd1 << $urandom_range(31));
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// one row of words; a noisy row may scramble its row numbers and lose or repeat its start and end flags
	task automatic queue_row(input int nwords, input logic [RowBits-1:0] row, input bit noisy);
		item_t it;
		for (int w = 0; w < nwords; w++) begin
			it.current_word = pixel_word();
			it.above_word = ($urandom_range(7) == 0) ? '0 : pixel_word();
			it.below_word = ($urandom_range(7) == 0) ? '0 : pixel_word();
			it.row_number = (noisy && $urandom_range(1)) ? RowBits'($urandom) : row;
			it.first_in_row = (w == 0);
			it.last_in_row = (w == nwords - 1);
			it.valid_bits = ($urandom_range(7) == 0) ? ValidBitsW'($urandom_range(63))
				: ValidBitsW'($urandom_range(32, 1));
			if (noisy && $urandom_range(2) == 0) begin
				it.first_in_row = 1'($urandom_range(1));
				it.last_in_row = 1'($urandom_range(1));
			end
			items_to_send.insert(items_to_send.size(), it);
		end
	endtask

	// mostly short well-formed rows, a few long ones, a few broken ones,
	// always closed by a clean row end so nothing is held across a register write
	task automatic random_rows(input int n_items);
		int queued;
		int nwords;
		bit noisy;
		queued = 0;
		while (queued < n_items) begin
			nwords = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
			noisy = ($urandom_range(7) == 0);
			row_cursor = ($urandom_range(15) == 0) ? RowBits'($urandom)
				: RowBits'(row_cursor + 1);
			queue_row(nwords, row_cursor, noisy);
			queued += nwords;
		end
		queue_row(1, row_cursor, 1'b0);
	endtask

	initial begin
		for (int i = 0; i < NumPatternRegs; i++)
			pat_word[i] = '1;
		pat_len = 1;
		held_pixels = '0;
		held_above = '0;
		held_below = '0;
		held_valid = 1'b0;
		prev_pixels = '0;
		pat_pos = '0;
		vert_on = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words under the reset pattern
		// inner pixels everywhere, full valid count
		push_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'd0, 1'b1, 1'b1, 6'd32);
		// horizontal run only, valid count past the word, top row number
		push_item(32'hffffffff, 32'h0, 32'h0, 16'hffff, 1'b1, 1'b1, 6'd63);
		// zero valid count clears the word
		push_item(32'h55555555, 32'h0, 32'h0, 16'd1, 1'b1, 1'b1, 6'd0);
		// solitary pixels
		push_item(32'h55555555, 32'h0, 32'h0, 16'd2, 1'b1, 1'b1, 6'd31);
		// vertical edge, single valid pixel
		push_item(32'hffffffff, 32'hffffffff, 32'h0, 16'd3, 1'b1, 1'b1, 6'd1);
		// neighbors across the word boundary
		push_item(32'h80000001, 32'h0, 32'h0, 16'd4, 1'b1, 1'b0, 6'd0);
		push_item(32'h00000001, 32'h0, 32'h0, 16'd4, 1'b0, 1'b1, 6'd16);
		// three-word row of mixed classes
		push_item(32'hffffffff, 32'haaaaaaaa, 32'h55555555, 16'd5, 1'b1, 1'b0, 6'd5);
		push_item(32'hffffffff, 32'h55555555, 32'haaaaaaaa, 16'd5, 1'b0, 1'b0, 6'd40);
		push_item(32'hffffffff, 32'hffffffff, 32'h0, 16'd5, 1'b0, 1'b1, 6'd32);
		// row start while a word is held: the held word closes its row
		push_item(32'h12345678, 32'hff00ff00, 32'h00ff00ff, 16'd6, 1'b1, 1'b0, 6'd0);
		push_item(32'h87654321, 32'h0, 32'hffffffff, 16'd7, 1'b1, 1'b0, 6'd0);
		push_item(32'hffff0000, 32'h0, 32'h0, 16'd7, 1'b0, 1'b1, 6'd20);
		// word with no start flag and nothing held opens a row
		push_item(32'h0f0f0f0f, 32'hf0f0f0f0, 32'h0, 16'd8, 1'b0, 1'b0, 6'd0);
		push_item(32'hffffffff, 32'h0, 32'h0, 16'd8, 1'b0, 1'b1, 6'd33);
		// empty word under full neighbors
		push_item(32'h0, 32'hffffffff, 32'hffffffff, 16'd9, 1'b1, 1'b1, 6'd32);
		drain();

		configure($urandom, $urandom, $urandom, $urandom, 32'd4);
		random_rows(PhaseItems);
		drain();

		// extreme patterns with no random idling on either side
		quiet <= 1'b1;
		configure(32'h0, 32'hffffffff, 32'haaaaaaaa, 32'h55555555, 32'd3);
		random_rows(PhaseItems);
		drain();
		quiet <= 1'b0;

		// length zero behaves as one
		configure($urandom, $urandom, $urandom, $urandom, 32'd0);
		random_rows(PhaseItems);
		drain();

		// length past the maximum saturates
		configure($urandom, $urandom, $urandom, $urandom, 32'd7);
		random_rows(PhaseItems);
		drain();

		configure(32'h0, $urandom, 32'hffffffff, $urandom, 32'd2);
		random_rows(PhaseItems);
		drain();

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/sesl_pkg.sv
rtl/core/sesl_front.sv
rtl/core/sesl_queue.sv
rtl/core/sesl_back.sv
rtl/core/styled_edge_scanline.sv
dv/testbench.sv
